FILE: src/pteq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pteq_pkg: shared types and constants for the timer event queue
// Word layouts, table sizing, op codes, result codes and ALU modes.
// ----------------------------------------------------------------------------
package pteq_pkg;

  // Table sizing and time width
  localparam int MAX_EVENTS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_BITS   = 32;   // 16..32 significant time bits
  localparam int TIME_W      = 32;   // field width of all time values
  localparam int IDX_W       = $clog2(MAX_EVENTS);
  localparam int CNT_W       = $clog2(MAX_EVENTS + 1);
  localparam int FIRE_LIMIT  = (MAX_RESULTS < MAX_EVENTS) ? MAX_RESULTS : MAX_EVENTS;

  // Largest representable time; also the time mask
  localparam logic [TIME_W-1:0] TIME_LIMIT = {TIME_W{1'b1}} >> (TIME_W - TIME_BITS);

  // Input op codes
  localparam logic [1:0] OP_ABS    = 2'd0;  // absolute time, explicit interval
  localparam logic [1:0] OP_DELAY  = 2'd1;  // after delay, optional repeat
  localparam logic [1:0] OP_REPNOW = 2'd2;  // absolute, repeat = time until trigger
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Result kinds
  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_FIRED  = 2'd1;
  localparam logic [1:0] RK_NONE   = 2'd2;

  // Insert status
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // Shared ALU modes
  localparam logic ALU_ADD_SAT = 1'b0;
  localparam logic ALU_SUB     = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] time_value;
    logic signed [31:0] repeat_interval;
    logic              repeat_enable;
    logic              event_kind;
    logic [7:0]        event_id;
  } pteq_in_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic              status;
    logic              fired_kind;
    logic [7:0]        fired_id;
    logic [TIME_W-1:0] fired_time;
    logic              last;
  } pteq_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] trig;
    logic [TIME_W-1:0] intv;
    logic              kind;
    logic [7:0]        id;
  } pteq_entry_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } pteq_alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;  // saturated sum or difference
    logic              ge;   // a >= b (subtract mode)
    logic              gt;   // a >  b (subtract mode)
  } pteq_alu_rsp_t;

endpackage

FILE: src/pteq_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pteq_alu: shared adder / comparator
// One 33-bit adder: saturating add of two times, or subtract with compare.
// ----------------------------------------------------------------------------
module pteq_alu import pteq_pkg::*; (
  input  pteq_alu_req_t req,
  output pteq_alu_rsp_t rsp
);

  logic [TIME_W-1:0] b_op;
  logic [TIME_W:0]   tot;
  logic              sat;

  // Subtract is a plus inverted b plus one
  assign b_op = (req.mode == ALU_SUB) ? ~req.b : req.b;
  assign tot  = {1'b0, req.a} + {1'b0, b_op} + {{TIME_W{1'b0}}, (req.mode == ALU_SUB)};

  // Clamp a sum beyond the largest time
  assign sat = (tot > {1'b0, TIME_LIMIT});

  always_comb begin
    rsp.ge = tot[TIME_W];
    rsp.gt = tot[TIME_W] && (tot[TIME_W-1:0] != '0);
    if (req.mode == ALU_ADD_SAT && sat) begin
      rsp.res = TIME_LIMIT;
    end else begin
      rsp.res = tot[TIME_W-1:0];
    end
  end

endmodule

FILE: src/periodic_timer_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_event_queue: sorted timer event table with tick firing
// Inserts timed events in trigger order and fires the due ones on a tick.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken when start is high and busy is low. Results come
//   back one per cycle, each marked by a one-cycle out_valid strobe; the
//   final result of a command has last set. The receiver cannot hold results.
//   Insert (ops 0..2): one status word, strobed after the insertion walk has
//   moved each later-triggering entry up one slot (0..15 of them). A full
//   table answers at once with a full status word, without going busy.
//   Tick: scans the table head one entry a cycle, then strobes one fired word
//   per due entry on back-to-back cycles, or one "none due" word. Afterwards,
//   while still busy, each fired entry is popped and, if repeating, its
//   trigger is advanced and it is sorted back in.
//   All adds and compares go through one shared adder, one per cycle; the
//   table walk is that adder plus one table read port.
//   Reset empties the table; entries are only read below the fill count.
// ----------------------------------------------------------------------------
module periodic_timer_event_queue import pteq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  pteq_in_t  in_word,
  output logic      busy,
  output logic      out_valid,
  output pteq_out_t out_word
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;  // compute trigger and interval
  localparam logic [2:0] S_INS    = 3'd2;  // insertion walk, one slot a cycle
  localparam logic [2:0] S_SCAN   = 3'd3;  // count due entries at head
  localparam logic [2:0] S_EMIT   = 3'd4;  // strobe fired words
  localparam logic [2:0] S_REMOVE = 3'd5;  // pop head entry
  localparam logic [2:0] S_READD  = 3'd6;  // advance repeating trigger

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;     // insert position or scan index
  logic [CNT_W-1:0]  n_r, n_nxt;         // number of due entries
  logic [CNT_W-1:0]  lo_r, lo_nxt;       // fired entries still at table head
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;     // fill count
  logic [1:0]        op_r, op_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] tv_r, tv_nxt;
  logic [TIME_W-1:0] tvraw_r, tvraw_nxt;
  logic [31:0]       rep_r, rep_nxt;
  logic              repen_r, repen_nxt;
  pteq_entry_t       hold_r, hold_nxt;
  logic              out_valid_r, out_valid_nxt;
  pteq_out_t         out_r, out_nxt;

  // Event table
  pteq_entry_t       ent_r [MAX_EVENTS];

  logic              do_shift, do_move, do_place;
  logic [CNT_W-1:0]  pos_m1;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  pteq_entry_t       rd_ent;
  pteq_alu_req_t     alu_req;
  pteq_alu_rsp_t     alu_rsp;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Single table read port
  assign pos_m1  = idx_r - CNT_W'(1);
  assign rd_addr = (state_r == S_INS) ? pos_m1[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign wr_addr = idx_r[IDX_W-1:0];
  assign rd_ent  = ent_r[rd_addr];

  // Shared adder operand select
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_PREP: begin
        if (op_r == OP_DELAY) begin
          alu_req.mode = ALU_ADD_SAT;
          alu_req.a    = now_r;
          alu_req.b    = tvraw_r;
        end else begin
          alu_req.mode = ALU_SUB;
          alu_req.a    = tv_r;
          alu_req.b    = now_r;
        end
      end
      S_INS: begin
        alu_req.mode = ALU_SUB;
        alu_req.a    = hold_r.trig;
        alu_req.b    = rd_ent.trig;
      end
      S_SCAN: begin
        alu_req.mode = ALU_SUB;
        alu_req.a    = now_r;
        alu_req.b    = rd_ent.trig;
      end
      S_READD: begin
        alu_req.mode = ALU_ADD_SAT;
        alu_req.a    = hold_r.trig;
        alu_req.b    = hold_r.intv;
      end
      default: begin
        alu_req.mode = ALU_SUB;
      end
    endcase
  end

  pteq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    tv_nxt        = tv_r;
    tvraw_nxt     = tvraw_r;
    rep_nxt       = rep_r;
    repen_nxt     = repen_r;
    hold_nxt      = hold_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    do_shift      = 1'b0;
    do_move       = 1'b0;
    do_place      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_word.op;
          now_nxt       = in_word.now_time & TIME_LIMIT;
          tv_nxt        = in_word.time_value & TIME_LIMIT;
          tvraw_nxt     = in_word.time_value;
          rep_nxt       = in_word.repeat_interval;
          repen_nxt     = in_word.repeat_enable;
          hold_nxt.kind = in_word.event_kind;
          hold_nxt.id   = in_word.event_id;
          if (in_word.op == OP_TICK) begin
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end else if (cnt_r == CNT_W'(MAX_EVENTS)) begin
            // table full: reject at once
            out_valid_nxt       = 1'b1;
            out_nxt.result_kind = RK_STATUS;
            out_nxt.status      = ST_FULL;
            out_nxt.last        = 1'b1;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end

      S_PREP: begin
        case (op_r)
          OP_ABS: begin
            hold_nxt.trig = tv_r;
            hold_nxt.intv = rep_r[31] ? '0 : rep_r;
          end
          OP_DELAY: begin
            hold_nxt.trig = alu_rsp.res;
            hold_nxt.intv = repen_r ? tvraw_r : '0;
          end
          default: begin
            hold_nxt.trig = tv_r;
            hold_nxt.intv = (repen_r && alu_rsp.gt) ? alu_rsp.res : '0;
          end
        endcase
        idx_nxt   = cnt_r;
        lo_nxt    = '0;
        state_nxt = S_INS;
      end

      S_INS: begin
        // move a later entry up while it triggers after the new one
        if ((idx_r > lo_r) && !alu_rsp.ge) begin
          do_move = 1'b1;
          idx_nxt = pos_m1;
        end else begin
          do_place = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (op_r == OP_TICK) begin
            state_nxt = (lo_r == '0) ? S_IDLE : S_REMOVE;
          end else begin
            out_valid_nxt       = 1'b1;
            out_nxt.result_kind = RK_STATUS;
            out_nxt.status      = ST_OK;
            out_nxt.last        = 1'b1;
            state_nxt           = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        if ((idx_r < cnt_r) && (idx_r < CNT_W'(FIRE_LIMIT)) && alu_rsp.ge) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else if (idx_r == '0) begin
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = RK_NONE;
          out_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          n_nxt     = idx_r;
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.result_kind = RK_FIRED;
        out_nxt.fired_kind  = rd_ent.kind;
        out_nxt.fired_id    = rd_ent.id;
        out_nxt.fired_time  = rd_ent.trig;
        out_nxt.last        = ((idx_r + CNT_W'(1)) == n_r);
        if (out_nxt.last) begin
          lo_nxt    = n_r;
          state_nxt = S_REMOVE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_REMOVE: begin
        // pop the head; repeating entries go back in behind the fired prefix
        hold_nxt = ent_r[0];
        do_shift = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        lo_nxt   = lo_r - CNT_W'(1);
        if (ent_r[0].intv != '0) begin
          state_nxt = S_READD;
        end else if (lo_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_READD: begin
        hold_nxt.trig = alu_rsp.res;
        idx_nxt       = cnt_r;
        state_nxt     = S_INS;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    now_r   <= now_nxt;
    tv_r    <= tv_nxt;
    tvraw_r <= tvraw_nxt;
    rep_r   <= rep_nxt;
    repen_r <= repen_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

  // Table writes: head pop shifts every slot down, insertion writes one slot
  always_ff @(posedge clk) begin
    if (do_shift) begin
      for (int i = 0; i < MAX_EVENTS - 1; i++) begin
        ent_r[i] <= ent_r[i + 1];
      end
    end
    if (do_move) begin
      ent_r[wr_addr] <= rd_ent;
    end
    if (do_place) begin
      ent_r[wr_addr] <= hold_r;
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_EVENTS))
    else $error("fill count beyond table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || (out_valid && out_word.status == ST_FULL)))
    else $error("accepted word neither started nor rejected");

  a_fire_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.result_kind == RK_FIRED) |-> $past(state_r == S_EMIT))
    else $error("fired word outside emit phase");

  a_ins_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (idx_r >= lo_r && idx_r <= cnt_r && cnt_r < CNT_W'(MAX_EVENTS)))
    else $error("insertion walk out of range");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.result_kind == RK_STATUS) |-> !busy)
    else $error("insert status while still busy");

endmodule
